// ----- rtl/drive_command_safety_interlock_top_assert.svh -----
// ----------------------------------------------------------------------------
// Drive command safety interlock assertion macros
// Shared forms for the concurrent checks in the interlock RTL.
// ----------------------------------------------------------------------------
`ifndef DRIVE_COMMAND_SAFETY_INTERLOCK_TOP_ASSERT_SVH
`define DRIVE_COMMAND_SAFETY_INTERLOCK_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCSI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dcsi: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DCSI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dcsi: next-cycle check failed");

`endif

// ----- rtl/dcsi_pkg.sv -----
// ----------------------------------------------------------------------------
// Drive command safety interlock package
// Types, codes and reset values shared by the interlock modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dcsi_pkg;

    localparam int unsigned NUM_SRC = 4;
    localparam logic [7:0]  MISS_MAX = 8'hFF;
    localparam logic [6:0]  PCT_MAX  = 7'd100;

    // Source slots of the miss counters.
    localparam int unsigned SRC_PEDAL = 0;
    localparam int unsigned SRC_BRAKE = 1;
    localparam int unsigned SRC_GEAR  = 2;
    localparam int unsigned SRC_MODE  = 3;

    // Gear codes.
    localparam logic [1:0] GEAR_PARK    = 2'd0;
    localparam logic [1:0] GEAR_REVERSE = 2'd1;
    localparam logic [1:0] GEAR_NEUTRAL = 2'd2;
    localparam logic [1:0] GEAR_DRIVE   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_BRAKE_CAP = 2'd0;
    localparam logic [1:0] REG_TIMEOUT   = 2'd1;
    localparam logic [1:0] REG_FALLBACK  = 2'd2;

    localparam logic [6:0] BRAKE_CAP_RST = 7'd10;
    localparam logic [7:0] TIMEOUT_RST   = 8'd10;
    localparam logic [1:0] FALLBACK_RST  = 2'd0;

    typedef struct packed {
        logic [6:0] brake_throttle_cap;
        logic [7:0] timeout_ticks;
        logic [1:0] fallback_mode;
    } cfg_t;

    typedef struct packed {
        logic       pedal_fresh;
        logic [7:0] pedal_percent;
        logic       brake_fresh;
        logic       brake_pressed;
        logic       gear_fresh;
        logic [2:0] gear_request;
        logic       mode_fresh;
        logic [1:0] mode_request;
    } tick_t;

    typedef struct packed {
        logic [6:0] safe_throttle;
        logic       brake_active;
        logic [1:0] safe_gear;
        logic [1:0] drive_mode;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/dcsi_cfg.sv -----
// ----------------------------------------------------------------------------
// Drive command safety interlock configuration registers
// Holds the brake cap, timeout and fallback mode written over the config port.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsi_cfg
    import dcsi_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output cfg_t            cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_BRAKE_CAP: cfg_next.brake_throttle_cap = cfg_data[6:0];
                REG_TIMEOUT:   cfg_next.timeout_ticks      = cfg_data;
                REG_FALLBACK:  cfg_next.fallback_mode      = cfg_data[1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.brake_throttle_cap <= BRAKE_CAP_RST;
            cfg_reg.timeout_ticks      <= TIMEOUT_RST;
            cfg_reg.fallback_mode      <= FALLBACK_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dcsi_core.sv -----
// ----------------------------------------------------------------------------
// Drive command safety interlock core
// Miss counters, held source values and the fallback, cap and gear logic.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsi_core
    import dcsi_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  advance,
    input  wire tick_t tick,
    input  wire cfg_t  cfg,
    output result_t    result
);

`include "drive_command_safety_interlock_top_assert.svh"

    logic [7:0] miss_cnt_reg  [NUM_SRC];
    logic [7:0] miss_cnt_next [NUM_SRC];
    result_t    held_reg;

    logic [NUM_SRC-1:0] fresh;
    logic [NUM_SRC-1:0] timed_out;
    logic [6:0]         pedal_clamped;
    logic [6:0]         thr;
    logic               rb;
    logic [1:0]         rg;
    logic [1:0]         rm;
    logic               from_park;
    logic               from_rd;
    logic               to_rd;
    logic               needs_brake;
    logic               park_exit;
    logic               pedal_cnt_zero;

    assign fresh[SRC_PEDAL] = tick.pedal_fresh;
    assign fresh[SRC_BRAKE] = tick.brake_fresh;
    assign fresh[SRC_GEAR]  = tick.gear_fresh;
    assign fresh[SRC_MODE]  = tick.mode_fresh;

    always_comb begin
        for (int i = 0; i < NUM_SRC; i++) begin
            if (fresh[i]) begin
                miss_cnt_next[i] = 8'd0;
            end else if (miss_cnt_reg[i] != MISS_MAX) begin
                miss_cnt_next[i] = miss_cnt_reg[i] + 8'd1;
            end else begin
                miss_cnt_next[i] = miss_cnt_reg[i];
            end
            timed_out[i] = (miss_cnt_next[i] >= cfg.timeout_ticks);
        end
    end

    assign pedal_clamped = (tick.pedal_percent > {1'b0, PCT_MAX}) ?
                           PCT_MAX : tick.pedal_percent[6:0];

    always_comb begin
        rb = timed_out[SRC_BRAKE] ? 1'b0 :
             (tick.brake_fresh ? tick.brake_pressed : held_reg.brake_active);

        if (timed_out[SRC_PEDAL]) begin
            thr = 7'd0;
        end else if (tick.pedal_fresh) begin
            thr = pedal_clamped;
        end else begin
            thr = held_reg.safe_throttle;
        end
        if (rb && (thr > cfg.brake_throttle_cap)) begin
            thr = cfg.brake_throttle_cap;
        end

        // Codes 4 to 7 are not gears, so the held gear stands as the request.
        if (timed_out[SRC_GEAR]) begin
            rg = GEAR_PARK;
        end else if (tick.gear_fresh && !tick.gear_request[2]) begin
            rg = tick.gear_request[1:0];
        end else begin
            rg = held_reg.safe_gear;
        end

        rm = timed_out[SRC_MODE] ? cfg.fallback_mode :
             (tick.mode_fresh ? tick.mode_request : held_reg.drive_mode);
    end

    assign from_park   = (held_reg.safe_gear == GEAR_PARK);
    assign from_rd     = (held_reg.safe_gear == GEAR_REVERSE) ||
                         (held_reg.safe_gear == GEAR_DRIVE);
    assign to_rd       = (rg == GEAR_REVERSE) || (rg == GEAR_DRIVE);
    assign needs_brake = (from_park && to_rd) || (from_rd && (rg == GEAR_PARK));

    always_comb begin
        result.safe_throttle = thr;
        result.brake_active  = rb;
        result.safe_gear     = (needs_brake && !rb) ? held_reg.safe_gear : rg;
        result.drive_mode    = rm;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg.safe_throttle <= 7'd0;
            held_reg.brake_active  <= 1'b0;
            held_reg.safe_gear     <= GEAR_PARK;
            held_reg.drive_mode    <= 2'd0;
            for (int i = 0; i < NUM_SRC; i++) begin
                miss_cnt_reg[i] <= 8'd0;
            end
        end else if (advance) begin
            held_reg <= result;
            for (int i = 0; i < NUM_SRC; i++) begin
                miss_cnt_reg[i] <= miss_cnt_next[i];
            end
        end
    end

    assign park_exit      = from_park && ((result.safe_gear == GEAR_REVERSE) ||
                                          (result.safe_gear == GEAR_DRIVE));
    assign pedal_cnt_zero = (miss_cnt_reg[SRC_PEDAL] == 8'd0);

    `DCSI_ASSERT_NOW(a_thr_range, aclk, aresetn, advance, result.safe_throttle <= PCT_MAX)
    `DCSI_ASSERT_NOW(a_brake_cap, aclk, aresetn, advance && rb, thr <= cfg.brake_throttle_cap)
    `DCSI_ASSERT_NOW(a_park_exit, aclk, aresetn, advance && park_exit, result.brake_active)
    `DCSI_ASSERT_NEXT(a_pedal_cnt_clr, aclk, aresetn, advance && fresh[SRC_PEDAL], pedal_cnt_zero)

endmodule

`default_nettype wire

// ----- rtl/drive_command_safety_interlock_top.sv -----
// ----------------------------------------------------------------------------
// Drive command safety interlock, top level
// One control tick in, one checked drive command out.
// ----------------------------------------------------------------------------
// Usage: each request on the s_ channel is one control tick with four sources
// (pedal, brake, gear, mode), their fresh flags in s_tuser. Each tick gives
// exactly one command on the m_ channel. The cfg_ channel writes the brake
// throttle cap (index 0), the source timeout (index 1) and the fallback mode
// (index 2); it is always ready, and the user must write it only while no tick
// is in flight; the block itself does not enforce this. The input register
// takes the tick at the accepting edge and the resolve logic loads the output
// register, which drives m_tvalid, once that register is free or draining.
// Throughput is one tick per cycle while m_tready stays high; the held values
// and miss counters update with each tick that moves on.
// A stalled m_tready holds the pending command; the input register still
// takes one tick, after which s_tready drops until the output drains.
// Synchronous active-low reset clears both valid flags, the miss counters and
// held values (Park, zero throttle, brake off, mode 0) and restores the
// configuration defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_command_safety_interlock_top
    import dcsi_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] pedal_percent, [8] brake_pressed, [11:9] gear_request,
    // [13:12] mode_request, [15:14] zero
    input  wire logic [15:0] s_tdata,
    // [0] pedal_fresh, [1] brake_fresh, [2] gear_fresh, [3] mode_fresh
    input  wire logic [3:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [6:0] safe_throttle, [7] brake_active, [9:8] safe_gear,
    // [11:10] drive_mode, [15:12] zero
    output logic [15:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

`include "drive_command_safety_interlock_top_assert.svh"

    cfg_t    cfg;
    tick_t   in_reg;
    logic    in_valid_reg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;

    // The staged tick moves on whenever the output register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    dcsi_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dcsi_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .tick    (in_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.pedal_fresh   <= s_tuser[0];
            in_reg.pedal_percent <= s_tdata[7:0];
            in_reg.brake_fresh   <= s_tuser[1];
            in_reg.brake_pressed <= s_tdata[8];
            in_reg.gear_fresh    <= s_tuser[2];
            in_reg.gear_request  <= s_tdata[11:9];
            in_reg.mode_fresh    <= s_tuser[3];
            in_reg.mode_request  <= s_tdata[13:12];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.drive_mode, out_reg.safe_gear,
                       out_reg.brake_active, out_reg.safe_throttle};

    `DCSI_ASSERT_NEXT(a_adv_to_out, aclk, aresetn, advance, out_valid_reg)
    `DCSI_ASSERT_NOW(a_no_overrun, aclk, aresetn, out_valid_reg && !m_tready, !advance)
    `DCSI_ASSERT_NEXT(a_stall_holds, aclk, aresetn, in_valid_reg && !s_tready, in_valid_reg)

endmodule

`default_nettype wire

// ----- bench/tb_drive_command_safety_interlock_top.sv -----
// ----------------------------------------------------------------------------
// Drive command safety interlock testbench
// Streams control ticks into the interlock and checks every drive command
// against an in-bench model of the miss counters, fallbacks, throttle clamp
// and cap, and the brake-gated gear interlock. Register settings change
// between phases while the block is idle. Both stream sides idle and stall
// in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_drive_command_safety_interlock_top;
    import dcsi_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned CALM_TAIL     = 50;
    localparam int unsigned PHASE_TICKS   = 115;

    // An index that names no register, and the range of codes that are no gear.
    localparam logic [1:0] REG_UNKNOWN   = 2'd3;
    localparam logic [2:0] GEAR_BAD_LOW  = 3'd4;
    localparam logic [2:0] GEAR_BAD_HIGH = 3'd7;

    typedef enum logic [1:0] {REQ_TICK, REQ_CFG, REQ_DRAIN} req_kind_t;

    typedef struct {
        req_kind_t  kind;
        tick_t      tick;
        logic [1:0] index;
        logic [7:0] data;
    } req_t;

    typedef struct {
        logic [6:0] throttle;
        logic       brake;
        logic [1:0] gear;
        logic [1:0] mode;
    } command_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    req_t        pending_q[$];
    command_t    command_q[$];
    int unsigned total_ticks = 0;
    int unsigned ticks_sent = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_left = 0;
    int unsigned gap_odds = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left = 0;
    int unsigned stall_odds = 0;
    logic        calm = 1'b0;

    // Model state: held command, per-source miss counts and registers.
    logic [6:0]  last_throttle;
    logic        last_brake;
    logic [1:0]  last_gear;
    logic [1:0]  last_mode;
    logic [7:0]  stale_count [NUM_SRC];
    logic [6:0]  cap_reg;
    logic [7:0]  timeout_reg;
    logic [1:0]  fallback_reg;

    // Stimulus generator state.
    int unsigned outage_left [NUM_SRC];
    int unsigned gen_timeout = TIMEOUT_RST;
    logic [2:0]  gen_gear = '0;

    drive_command_safety_interlock_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Advances one source's miss count and reports whether it has timed out.
    function automatic logic bump_miss(int unsigned src, logic fresh);
        if (fresh) begin
            stale_count[src] = '0;
        end else if (stale_count[src] < MISS_MAX) begin
            stale_count[src] = stale_count[src] + 8'd1;
        end
        return stale_count[src] >= timeout_reg;
    endfunction

    function automatic command_t resolve_tick(tick_t t);
        logic     pedal_out;
        logic     brake_out;
        logic     gear_out;
        logic     mode_out;
        logic     from_park;
        logic     from_moving;
        logic     to_moving;
        logic [1:0] want_gear;
        command_t cmd;
        pedal_out = bump_miss(SRC_PEDAL, t.pedal_fresh);
        brake_out = bump_miss(SRC_BRAKE, t.brake_fresh);
        gear_out  = bump_miss(SRC_GEAR, t.gear_fresh);
        mode_out  = bump_miss(SRC_MODE, t.mode_fresh);

        if (pedal_out) begin
            cmd.throttle = '0;
        end else if (t.pedal_fresh) begin
            cmd.throttle = (t.pedal_percent > PCT_MAX) ? PCT_MAX : t.pedal_percent[6:0];
        end else begin
            cmd.throttle = last_throttle;
        end

        cmd.brake = brake_out ? 1'b0 : (t.brake_fresh ? t.brake_pressed : last_brake);

        // A fresh but invalid gear code leaves the held gear as the request.
        if (gear_out) begin
            want_gear = GEAR_PARK;
        end else if (t.gear_fresh && t.gear_request <= {1'b0, GEAR_DRIVE}) begin
            want_gear = t.gear_request[1:0];
        end else begin
            want_gear = last_gear;
        end

        cmd.mode = mode_out ? fallback_reg : (t.mode_fresh ? t.mode_request : last_mode);

        if (cmd.brake && cmd.throttle > cap_reg) begin
            cmd.throttle = cap_reg;
        end

        // Entering or leaving Park from Reverse or Drive needs the brake.
        from_park   = (last_gear == GEAR_PARK);
        from_moving = (last_gear == GEAR_REVERSE) || (last_gear == GEAR_DRIVE);
        to_moving   = (want_gear == GEAR_REVERSE) || (want_gear == GEAR_DRIVE);
        cmd.gear = want_gear;
        if (((from_park && to_moving) || (from_moving && want_gear == GEAR_PARK))
                && !cmd.brake) begin
            cmd.gear = last_gear;
        end

        last_throttle = cmd.throttle;
        last_brake    = cmd.brake;
        last_gear     = cmd.gear;
        last_mode     = cmd.mode;
        return cmd;
    endfunction

    task automatic push_tick(input logic pf, input logic [7:0] pedal, input logic bf,
                             input logic brk, input logic gf, input logic [2:0] gear,
                             input logic mf, input logic [1:0] mode);
        req_t req;
        req.kind = REQ_TICK;
        req.index = '0;
        req.data = '0;
        req.tick.pedal_fresh = pf;
        req.tick.pedal_percent = pedal;
        req.tick.brake_fresh = bf;
        req.tick.brake_pressed = brk;
        req.tick.gear_fresh = gf;
        req.tick.gear_request = gear;
        req.tick.mode_fresh = mf;
        req.tick.mode_request = mode;
        pending_q.push_back(req);
        total_ticks++;
    endtask

    task automatic push_ctrl(input req_kind_t kind, input logic [1:0] index,
                             input logic [7:0] data);
        req_t req;
        req.kind = kind;
        req.tick = '0;
        req.index = index;
        req.data = data;
        pending_q.push_back(req);
        if (kind == REQ_CFG && index == REG_TIMEOUT) begin
            gen_timeout = data;
        end
    endtask

    // Mostly fresh ticks, with outages long enough to cross the timeout.
    task automatic push_random_ticks(input int unsigned count);
        logic       fresh [NUM_SRC];
        logic [7:0] pedal;
        for (int unsigned n = 0; n < count; n++) begin
            for (int unsigned src = 0; src < NUM_SRC; src++) begin
                if (outage_left[src] != 0) begin
                    outage_left[src]--;
                    fresh[src] = 1'b0;
                end else if ($urandom_range(0, 39) == 0) begin
                    outage_left[src] = $urandom_range(0, gen_timeout + 3);
                    fresh[src] = 1'b0;
                end else begin
                    fresh[src] = ($urandom_range(0, 19) != 0);
                end
            end
            pedal = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 100));
            if ($urandom_range(0, 3) == 0) begin
                gen_gear = ($urandom_range(0, 7) == 0)
                           ? 3'($urandom_range(GEAR_BAD_LOW, GEAR_BAD_HIGH))
                           : 3'($urandom_range(0, 3));
            end
            push_tick(fresh[SRC_PEDAL], pedal, fresh[SRC_BRAKE], 1'($urandom_range(0, 1)),
                      fresh[SRC_GEAR], gen_gear, fresh[SRC_MODE], 2'($urandom_range(0, 3)));
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    initial begin
        for (int unsigned src = 0; src < NUM_SRC; src++) begin
            outage_left[src] = 0;
        end

        // Directed ticks under the reset settings.
        push_tick(1, 8'd0,   1, 0, 1, 3'(GEAR_PARK),    1, 2'd0);
        push_tick(1, 8'd255, 1, 0, 1, 3'(GEAR_PARK),    1, 2'd3);
        push_tick(1, 8'd100, 1, 1, 1, 3'(GEAR_REVERSE), 1, 2'd1);
        push_tick(1, 8'd101, 1, 0, 1, 3'(GEAR_PARK),    1, 2'd2);
        push_tick(1, 8'd60,  1, 0, 1, 3'(GEAR_DRIVE),   1, 2'd0);
        push_tick(0, 8'd200, 0, 1, 0, 3'(GEAR_PARK),    0, 2'd3);
        push_tick(1, 8'd5,   1, 1, 1, 3'(GEAR_NEUTRAL), 1, 2'd1);
        push_tick(1, 8'd5,   1, 0, 1, GEAR_BAD_HIGH,    1, 2'd1);
        push_tick(1, 8'd5,   1, 0, 1, GEAR_BAD_LOW,     1, 2'd1);
        push_tick(1, 8'd5,   1, 0, 1, 3'(GEAR_PARK),    1, 2'd1);
        push_tick(1, 8'd5,   1, 0, 1, 3'(GEAR_DRIVE),   1, 2'd1);
        push_tick(1, 8'd80,  1, 1, 1, 3'(GEAR_DRIVE),   1, 2'd3);
        // Pedal, gear and mode go stale until they time out; the gear
        // fallback to Park is held off because the brake is released.
        for (int i = 0; i < 10; i++) begin
            push_tick(0, 8'd90, 1, 0, 0, 3'(GEAR_REVERSE), 0, 2'd2);
        end
        push_tick(0, 8'd90, 0, 1, 0, 3'(GEAR_DRIVE), 0, 2'd2);
        push_tick(1, 8'd90, 1, 1, 0, 3'(GEAR_DRIVE), 0, 2'd2);
        push_tick(1, 8'd0,  1, 0, 1, 3'(GEAR_PARK),  1, 2'd0);

        for (int unsigned phase = 0; phase < 8; phase++) begin
            case (phase)
                0: ;
                1: begin
                    push_ctrl(REQ_CFG, REG_BRAKE_CAP, 8'd0);
                    push_ctrl(REQ_CFG, REG_TIMEOUT, 8'd1);
                    push_ctrl(REQ_CFG, REG_FALLBACK, 8'd3);
                end
                2: begin
                    // Cap above 100 leaves only the clamp in effect.
                    push_ctrl(REQ_CFG, REG_BRAKE_CAP, 8'hFF);
                    push_ctrl(REQ_CFG, REG_TIMEOUT, 8'hFF);
                    push_ctrl(REQ_CFG, REG_FALLBACK, 8'hFF);
                    push_ctrl(REQ_CFG, REG_UNKNOWN, 8'hA5);
                end
                3: begin
                    // A zero timeout keeps every source in fallback.
                    push_ctrl(REQ_CFG, REG_TIMEOUT, 8'd0);
                    push_ctrl(REQ_CFG, REG_BRAKE_CAP, 8'd100);
                    push_ctrl(REQ_CFG, REG_FALLBACK, 8'd2);
                end
                default: begin
                    push_ctrl(REQ_CFG, REG_BRAKE_CAP, 8'($urandom_range(0, 127)));
                    push_ctrl(REQ_CFG, REG_TIMEOUT, 8'($urandom_range(1, 24)));
                    push_ctrl(REQ_CFG, REG_FALLBACK, 8'($urandom_range(0, 3)));
                    if ($urandom_range(0, 1) == 0) begin
                        push_ctrl(REQ_CFG, REG_UNKNOWN, 8'($urandom_range(0, 255)));
                    end
                end
            endcase
            push_random_ticks(PHASE_TICKS / 2);
            push_ctrl(REQ_DRAIN, '0, '0);
            push_random_ticks(PHASE_TICKS - PHASE_TICKS / 2);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || s_tvalid || cfg_valid || command_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    always @(posedge aclk) begin : drive_requests
        req_t req;
        logic next_s_valid;
        logic next_cfg_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            cfg_valid <= 1'b0;
            gap_left = 0;
            quiet_cycles = 0;
        end else begin
            next_s_valid = s_tvalid && !s_tready;
            next_cfg_valid = cfg_valid && !cfg_ready;
            if (!next_s_valid && !next_cfg_valid && pending_q.size() != 0) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_q[0].kind == REQ_TICK) begin
                    req = pending_q.pop_front();
                    s_tdata <= {2'b00, req.tick.mode_request, req.tick.gear_request,
                                req.tick.brake_pressed, req.tick.pedal_percent};
                    s_tuser <= {req.tick.mode_fresh, req.tick.gear_fresh,
                                req.tick.brake_fresh, req.tick.pedal_fresh};
                    next_s_valid = 1'b1;
                    if (ticks_sent % 64 == 0) begin
                        case ($urandom_range(0, 2))
                            0: gap_odds = 0;
                            1: gap_odds = 10;
                            default: gap_odds = 35;
                        endcase
                    end
                    ticks_sent++;
                    if (ticks_sent + CALM_TAIL >= total_ticks) begin
                        calm <= 1'b1;
                    end else if ($urandom_range(0, 99) < gap_odds) begin
                        gap_left = $urandom_range(1, 17);
                    end
                end else if (!s_tvalid && !cfg_valid && !m_tvalid
                             && command_q.size() == 0) begin
                    // Registers change only once the pipeline has drained.
                    if (quiet_cycles < SETTLE_CYCLES) begin
                        quiet_cycles++;
                    end else begin
                        quiet_cycles = 0;
                        req = pending_q.pop_front();
                        if (req.kind == REQ_CFG) begin
                            cfg_index <= req.index;
                            cfg_data <= req.data;
                            next_cfg_valid = 1'b1;
                        end
                    end
                end else begin
                    quiet_cycles = 0;
                end
            end
            s_tvalid <= next_s_valid;
            cfg_valid <= next_cfg_valid;
        end
    end

    always @(posedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (cycle_count % 200 == 0) begin
                stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < stall_odds) begin
                stall_left = $urandom_range(0, 16);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watch_ports
        tick_t    tick;
        command_t want;
        if (!aresetn) begin
            last_throttle = '0;
            last_brake = 1'b0;
            last_gear = GEAR_PARK;
            last_mode = '0;
            for (int unsigned src = 0; src < NUM_SRC; src++) begin
                stale_count[src] = '0;
            end
            cap_reg = BRAKE_CAP_RST;
            timeout_reg = TIMEOUT_RST;
            fallback_reg = FALLBACK_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BRAKE_CAP: cap_reg = cfg_data[6:0];
                    REG_TIMEOUT:   timeout_reg = cfg_data;
                    REG_FALLBACK:  fallback_reg = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                tick.pedal_fresh = s_tuser[0];
                tick.brake_fresh = s_tuser[1];
                tick.gear_fresh = s_tuser[2];
                tick.mode_fresh = s_tuser[3];
                tick.pedal_percent = s_tdata[7:0];
                tick.brake_pressed = s_tdata[8];
                tick.gear_request = s_tdata[11:9];
                tick.mode_request = s_tdata[13:12];
                command_q.push_back(resolve_tick(tick));
            end
            if (m_tvalid && m_tready) begin
                if (command_q.size() == 0) begin
                    $display("%0t: unexpected command, expected none actual 0x%04h",
                             $time, m_tdata);
                    err_count++;
                end else begin
                    want = command_q.pop_front();
                    check_field("safe_throttle", want.throttle, m_tdata[6:0]);
                    check_field("brake_active", want.brake, m_tdata[7]);
                    check_field("safe_gear", want.gear, m_tdata[9:8]);
                    check_field("drive_mode", want.mode, m_tdata[11:10]);
                    check_field("padding", 0, m_tdata[15:12]);
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/dcsi_pkg.sv
rtl/dcsi_cfg.sv
rtl/dcsi_core.sv
rtl/drive_command_safety_interlock_top.sv
bench/tb_drive_command_safety_interlock_top.sv
